// ===== rtl/rmst_pkg.sv =====
// rmst_pkg: shared constants, types and helpers for the range minimum segment tree
// no dependencies
package rmst_pkg;

    localparam int LEAVES = 1024;
    localparam int DEPTH  = 2 * LEAVES;
    localparam int NODE_W = $clog2(DEPTH);
    localparam int PTR_W  = NODE_W + 1;

    localparam int VAL_W  = 31;
    localparam int IDX_W  = 10;
    localparam int END_W  = 11;

    // request kinds carried on req_type
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [NODE_W-1:0] t_node;
    typedef logic [PTR_W-1:0]  t_ptr;

    localparam t_value SENTINEL  = t_value'(2000000000);
    localparam t_value VALUE_TOP = {VAL_W{1'b1}};

    function automatic t_value min_val(input t_value a, input t_value b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== rtl/range_minimum_segment_tree.sv =====
// range_minimum_segment_tree: segment tree with point update and range minimum query
// depends on rmst_pkg and rmst_ram
//
// usage
//   input channel (i_in_valid / o_in_ready) takes one word per item: i_req_type 0 writes
//   i_entry_value to leaf i_entry_index and refreshes its ancestors, giving no result;
//   i_req_type 1 asks for the minimum over leaves [i_range_start, i_range_end)
//   output channel (o_out_valid / i_out_ready) returns one word per query on
//   o_range_minimum; an empty range (after clamping the end to the leaf count)
//   returns 2000000000
//   all tree nodes live in one single-port ram with a registered read
//   an update does one write of the leaf, then per level one sibling read and one
//   parent write, up to the root
//   a query takes one lo step and one hi step per level of the lo/hi walk, since each
//   level needs up to two reads through the one ram port
//   one item is worked at a time; o_in_ready is high only while the sequencer idles
//   after reset the ram is swept to zero, one node per cycle over all 2 * leaves nodes
//   (2048), with o_in_ready low throughout
//   a finished result sits in an output register; a stalled receiver holds the next
//   query in its final step until that register frees, and no new item is taken meanwhile
module range_minimum_segment_tree (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [rmst_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [rmst_pkg::VAL_W-1:0]     i_entry_value,
    input  logic [rmst_pkg::IDX_W-1:0]     i_range_start,
    input  logic [rmst_pkg::END_W-1:0]     i_range_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rmst_pkg::VAL_W-1:0]     o_range_minimum
);

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,  // zeroing sweep after reset
        S_IDLE    = 8'b0000_0010,  // waiting for a word
        S_U_LEAF  = 8'b0000_0100,  // write the leaf
        S_U_READ  = 8'b0000_1000,  // read sibling of current node
        S_U_WRITE = 8'b0001_0000,  // write parent minimum
        S_Q_LO    = 8'b0010_0000,  // left edge of the walk
        S_Q_HI    = 8'b0100_0000,  // right edge of the walk, then go up a level
        S_DONE    = 8'b1000_0000   // hand the result to the output register
    } t_state;

    t_state            r_state, n_state;
    rmst_pkg::t_node   r_clr, n_clr;     // clearing sweep address
    rmst_pkg::t_node   r_cur, n_cur;     // update: node just written
    rmst_pkg::t_value  r_val, n_val;     // update: value of r_cur
    rmst_pkg::t_ptr    r_lo, n_lo;       // query: left bound, inclusive
    rmst_pkg::t_ptr    r_hi, n_hi;       // query: right bound, exclusive
    rmst_pkg::t_value  r_best, n_best;   // query: running minimum
    logic              r_pend, n_pend;   // query: ram read in flight
    logic              r_out_valid, n_out_valid;
    rmst_pkg::t_value  r_out, n_out;

    // ram port
    logic              w_we;
    rmst_pkg::t_node   w_addr;
    rmst_pkg::t_value  w_wdata;
    rmst_pkg::t_value  w_rdata;

    // decode of the incoming word
    logic [31:0]       w_end_c;
    logic [31:0]       w_start;
    logic              w_empty;
    logic              w_idx_ok;
    rmst_pkg::t_value  w_fold;           // best with the pending read folded in
    rmst_pkg::t_value  w_sib_min;
    rmst_pkg::t_node   w_parent;
    logic              w_out_free;

    rmst_ram #(
        .WIDTH (rmst_pkg::VAL_W),
        .DEPTH (rmst_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // clamp the range end to the leaf count; empty when start is not below it
    assign w_start  = 32'(i_range_start);
    assign w_end_c  = (32'(i_range_end) > 32'(rmst_pkg::LEAVES)) ?
                      32'(rmst_pkg::LEAVES) : 32'(i_range_end);
    assign w_empty  = (w_start >= w_end_c);
    assign w_idx_ok = (32'(i_entry_index) < 32'(rmst_pkg::LEAVES));

    assign w_fold     = r_pend ? rmst_pkg::min_val(r_best, w_rdata) : r_best;
    assign w_sib_min  = rmst_pkg::min_val(r_val, w_rdata);
    assign w_parent   = r_cur >> 1;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_range_minimum = r_out;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_best      = r_best;
        n_pend      = 1'b0;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_we        = 1'b0;
        w_addr      = r_cur;
        w_wdata     = r_val;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_addr  = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == rmst_pkg::t_node'(rmst_pkg::DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == rmst_pkg::REQ_WRITE) begin
                        n_cur = rmst_pkg::t_node'(32'(rmst_pkg::LEAVES) +
                                                  32'(i_entry_index));
                        n_val = i_entry_value;
                        // writes beyond the leaves are dropped
                        n_state = w_idx_ok ? S_U_LEAF : S_IDLE;
                    end else if (w_empty) begin
                        n_best  = rmst_pkg::SENTINEL;
                        n_state = S_DONE;
                    end else begin
                        n_lo    = rmst_pkg::t_ptr'(32'(rmst_pkg::LEAVES) + w_start);
                        n_hi    = rmst_pkg::t_ptr'(32'(rmst_pkg::LEAVES) + w_end_c);
                        n_best  = rmst_pkg::VALUE_TOP;
                        n_state = S_Q_LO;
                    end
                end
            end
            S_U_LEAF: begin
                w_we    = 1'b1;
                w_addr  = r_cur;
                w_wdata = r_val;
                n_state = S_U_READ;
            end
            S_U_READ: begin
                w_addr  = r_cur ^ rmst_pkg::t_node'(1);
                n_state = S_U_WRITE;
            end
            S_U_WRITE: begin
                w_we    = 1'b1;
                w_addr  = w_parent;
                w_wdata = w_sib_min;
                n_val   = w_sib_min;
                n_cur   = w_parent;
                n_state = (w_parent == rmst_pkg::t_node'(1)) ? S_IDLE : S_U_READ;
            end
            S_Q_LO: begin
                n_best = w_fold;
                w_addr = r_lo[rmst_pkg::NODE_W-1:0];
                if (r_lo >= r_hi) begin
                    n_state = S_DONE;
                end else begin
                    if (r_lo[0]) begin
                        n_pend = 1'b1;
                        n_lo   = r_lo + 1'b1;
                    end
                    n_state = S_Q_HI;
                end
            end
            S_Q_HI: begin
                n_best = w_fold;
                w_addr = rmst_pkg::t_node'(r_hi - 1'b1);
                if (r_hi[0]) begin
                    n_pend = 1'b1;
                end
                // an odd hi steps back by one first, same parent either way
                n_lo    = r_lo >> 1;
                n_hi    = r_hi >> 1;
                n_state = S_Q_LO;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_best;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_cur  <= n_cur;
        r_val  <= n_val;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_best <= n_best;
        r_out  <= n_out;
    end

    // the query walk only reads the tree
    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_LO || r_state == S_Q_HI) |-> !w_we)
        else $error("ram written during a query walk");

    // a pending read is always consumed by the next query step
    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_Q_LO || r_state == S_Q_HI))
        else $error("read result arrived outside the query walk");

    // ancestor refresh never climbs past the root
    a_no_node_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U_WRITE) |-> (w_parent != '0))
        else $error("update wrote the unused node zero");

    // a result word only comes out of the final query step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result produced outside the final query step");

    // input is refused for the whole clearing sweep
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_state == S_CLEAR || r_state == S_IDLE))
        else $error("clearing sweep left early");

endmodule

// ===== rtl/rmst_ram.sv =====
// rmst_ram: generic single-port synchronous ram, registered read
// no dependencies
module rmst_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
